// ----- design/dpbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpbm_pkg
// Shared widths, status codes and helpers for the demand paged byte memory.
// ----------------------------------------------------------------------------
package dpbm_pkg;

  localparam int SIZE_W   = 4;
  localparam int ADDR_W   = 32;
  localparam int WDATA_W  = 32;
  localparam int RDATA_W  = 64;
  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNALIGNED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME  = 3'd4;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [7:0] BYTE_MASK = 8'hFF;

  // alignment checker result
  typedef struct packed {
    logic done;
    logic aligned;
  } rem_stat_t;

  function automatic logic size_is_pow2(input logic [SIZE_W-1:0] s);
    return (s == 4'd1) || (s == 4'd2) || (s == 4'd4) || (s == 4'd8);
  endfunction

endpackage
`default_nettype wire

// ----- design/dpbm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpbm_ram
// Simple synchronous RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dpbm_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 20
) (
  input  wire          clk,
  input  wire          we,
  input  wire [AW-1:0] waddr,
  input  wire [DW-1:0] wdata,
  input  wire          re,
  input  wire [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/dpbm_rem_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpbm_rem_unit
// Alignment check: is the page offset a multiple of the access size.
// Power-of-two sizes resolve by a mask test, others by a bit-serial remainder.
// ----------------------------------------------------------------------------
module dpbm_rem_unit #(
  parameter int OFF_W = 12
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire [OFF_W-1:0]             dividend,
  input  wire [dpbm_pkg::SIZE_W-1:0]  divisor,
  output dpbm_pkg::rem_stat_t         stat
);

  import dpbm_pkg::*;

  localparam int CW = $clog2(OFF_W);

  logic              busy;
  logic              done;
  logic              aligned;
  logic [CW-1:0]     cnt;
  logic [OFF_W-1:0]  shreg;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] dvs;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W-1:0] rem_next;
  logic [OFF_W-1:0]  low_mask;

  assign trial    = {rem, shreg[OFF_W-1]};
  assign rem_next = (trial >= {1'b0, dvs}) ? SIZE_W'(trial - {1'b0, dvs})
                                           : trial[SIZE_W-1:0];
  assign low_mask = {{(OFF_W-SIZE_W){1'b0}}, SIZE_W'(divisor - 4'd1)};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      if (size_is_pow2(divisor)) begin
        done    <= 1'b1;
        busy    <= 1'b0;
        aligned <= ((dividend & low_mask) == '0);
      end else begin
        done  <= 1'b0;
        busy  <= 1'b1;
        shreg <= dividend;
        dvs   <= divisor;
        rem   <= '0;
        cnt   <= '0;
      end
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[OFF_W-2:0], 1'b0};
      cnt   <= CW'(cnt + 1'b1);
      if (cnt == CW'(OFF_W - 1)) begin
        busy    <= 1'b0;
        done    <= 1'b1;
        aligned <= (rem_next == '0);
      end
    end
  end

  assign stat.done    = done;
  assign stat.aligned = aligned;

endmodule
`default_nettype wire

// ----- design/demand_paged_byte_memory.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// demand_paged_byte_memory
// Sparse 32-bit byte memory; pages bind to frames on their first aligned, nonzero-size write.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  ----------------------------------
// request  in         in_valid/in_ready    req_type address size_bytes
//                                          write_data
// response out        out_valid/out_ready  read_data status
//
// Clear: after reset the frame store is swept to zero, one word per cycle,
//   FRAME_COUNT*PAGE_BYTES/8 words (8192 by default), with in_ready low.
// Per transaction: the time from accept to the next accept is set by the
//   serial page-number search through the one read port of the tag RAM and,
//   for non power-of-two sizes, by the bit-serial alignment check; the next
//   request is taken only once the last response is in the output register.
// Stalls: one finished response is held in the output register while the
//   next request is taken; the block waits before retiring a second one.
// Reset: synchronous, clears frames_in_use and control state.
// ----------------------------------------------------------------------------
module demand_paged_byte_memory #(
  parameter int PAGE_BYTES  = 4096,
  parameter int FRAME_COUNT = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire                           req_type,
  input  wire [dpbm_pkg::ADDR_W-1:0]    address,
  input  wire [dpbm_pkg::SIZE_W-1:0]    size_bytes,
  input  wire [dpbm_pkg::WDATA_W-1:0]   write_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [dpbm_pkg::RDATA_W-1:0]  read_data,
  output logic [dpbm_pkg::STATUS_W-1:0] status
);

  import dpbm_pkg::*;

  localparam int OFF_W          = $clog2(PAGE_BYTES);
  localparam int PAGE_W         = ADDR_W - OFF_W;
  localparam int WOFF_W         = OFF_W - 3;
  localparam int FRAME_W        = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_W          = $clog2(FRAME_COUNT + 1);
  localparam int WORDS_PER_PAGE = PAGE_BYTES / 8;
  localparam int STORE_WORDS    = FRAME_COUNT * WORDS_PER_PAGE;
  localparam int STORE_AW       = $clog2(STORE_WORDS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_ACCESS = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]          state;
  logic [STORE_AW-1:0] clr_addr;
  logic [CNT_W-1:0]    frames_in_use;

  // latched request
  logic               req_write;
  logic [PAGE_W-1:0]  req_page;
  logic [OFF_W-1:0]   req_off;
  logic [SIZE_W-1:0]  req_size;
  logic [WDATA_W-1:0] req_wdata;

  // tag search
  logic [CNT_W-1:0]   scan_idx;
  logic               cmp_vld;
  logic [FRAME_W-1:0] cmp_idx;
  logic               scan_done;
  logic               hit;
  logic [FRAME_W-1:0] hit_frame;

  // pending response
  logic [RDATA_W-1:0]  res_data;
  logic [STATUS_W-1:0] res_status;

  logic                accept;
  logic                scan_issue;
  logic                scan_hit;
  logic                decide;
  logic                frames_full;
  logic                write_size_ok;
  logic [FRAME_W-1:0]  frame_sel;
  logic [FRAME_W+WOFF_W-1:0] word_full;
  logic [STORE_AW-1:0] word_addr;

  logic                tag_we;
  logic [PAGE_W-1:0]   tag_rdata;
  logic                store_we;
  logic                store_re;
  logic [STORE_AW-1:0] store_waddr;
  logic [RDATA_W-1:0]  store_wdata;
  logic [RDATA_W-1:0]  store_rdata;

  logic [5:0]          shamt;
  logic [RDATA_W-1:0]  smask;
  logic [RDATA_W-1:0]  wmask;
  logic [RDATA_W-1:0]  wval;
  logic [RDATA_W-1:0]  rd_val;
  logic [RDATA_W-1:0]  merged;

  rem_stat_t           rem_stat;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Alignment check runs alongside the tag search
  // --------------------------------------------------------------------------
  dpbm_rem_unit #(
    .OFF_W(OFF_W)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && (size_bytes != '0)),
    .dividend(address[OFF_W-1:0]),
    .divisor (size_bytes),
    .stat    (rem_stat)
  );

  // --------------------------------------------------------------------------
  // Tag RAM: page number per frame, scanned one entry per cycle
  // --------------------------------------------------------------------------
  assign scan_hit   = (state == S_SEARCH) && cmp_vld && (tag_rdata == req_page);
  assign scan_issue = (state == S_SEARCH) && !scan_done && !scan_hit &&
                      (scan_idx < frames_in_use);

  dpbm_ram #(
    .DEPTH(FRAME_COUNT),
    .AW   (FRAME_W),
    .DW   (PAGE_W)
  ) u_tag_ram (
    .clk  (clk),
    .we   (tag_we),
    .waddr(frames_in_use[FRAME_W-1:0]),
    .wdata(req_page),
    .re   (scan_issue),
    .raddr(scan_idx[FRAME_W-1:0]),
    .rdata(tag_rdata)
  );

  // --------------------------------------------------------------------------
  // Decision once both the search and the alignment check are in
  // --------------------------------------------------------------------------
  assign decide        = (state == S_SEARCH) && scan_done && rem_stat.done;
  assign frames_full   = (frames_in_use == CNT_W'(FRAME_COUNT));
  assign write_size_ok = (req_size == 4'd1) || (req_size == 4'd2) || (req_size == 4'd4);

  // a new page takes the next free frame
  assign tag_we = decide && rem_stat.aligned && (req_write == REQ_WRITE) &&
                  !hit && !frames_full;

  always_comb begin
    store_re = 1'b0;
    if (decide && rem_stat.aligned) begin
      if (req_write == REQ_READ) begin
        store_re = hit && size_is_pow2(req_size);
      end else begin
        store_re = (hit || !frames_full) && write_size_ok;
      end
    end
  end

  assign frame_sel = (state == S_SEARCH && !hit) ? frames_in_use[FRAME_W-1:0] : hit_frame;
  assign word_full = {frame_sel, req_off[OFF_W-1:3]};
  assign word_addr = word_full[STORE_AW-1:0];

  // --------------------------------------------------------------------------
  // Frame store: read, or read-modify-write, of one 64-bit word
  // --------------------------------------------------------------------------
  assign shamt = {req_off[2:0], 3'b000};

  always_comb begin
    unique case (req_size)
      4'd1:    smask = {{56{1'b0}}, BYTE_MASK};
      4'd2:    smask = {{48{1'b0}}, {2{BYTE_MASK}}};
      4'd4:    smask = {{32{1'b0}}, {4{BYTE_MASK}}};
      default: smask = {8{BYTE_MASK}};
    endcase
  end

  assign rd_val = (store_rdata >> shamt) & smask;
  assign wmask  = smask << shamt;
  assign wval   = ({{(RDATA_W-WDATA_W){1'b0}}, req_wdata} << shamt) & wmask;
  assign merged = (store_rdata & ~wmask) | wval;

  assign store_we    = (state == S_CLEAR) || (state == S_ACCESS && req_write == REQ_WRITE);
  assign store_waddr = (state == S_CLEAR) ? clr_addr : word_addr;
  assign store_wdata = (state == S_CLEAR) ? '0 : merged;

  dpbm_ram #(
    .DEPTH(STORE_WORDS),
    .AW   (STORE_AW),
    .DW   (RDATA_W)
  ) u_store_ram (
    .clk  (clk),
    .we   (store_we),
    .waddr(store_waddr),
    .wdata(store_wdata),
    .re   (store_re),
    .raddr(word_addr),
    .rdata(store_rdata)
  );

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      frames_in_use <= '0;
      scan_done     <= 1'b0;
      cmp_vld       <= 1'b0;
      hit           <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= STORE_AW'(clr_addr + 1'b1);
          if (clr_addr == STORE_AW'(STORE_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            req_write <= req_type;
            req_page  <= address[ADDR_W-1:OFF_W];
            req_off   <= address[OFF_W-1:0];
            req_size  <= size_bytes;
            req_wdata <= write_data;
            scan_idx  <= '0;
            cmp_vld   <= 1'b0;
            scan_done <= 1'b0;
            hit       <= 1'b0;
            if (size_bytes == '0) begin
              res_status <= ST_BAD_SIZE;
              res_data   <= '0;
              state      <= S_RESP;
            end else begin
              state <= S_SEARCH;
            end
          end
        end

        S_SEARCH: begin
          // pipelined scan: issue one tag read, compare the previous one
          if (scan_hit) begin
            hit       <= 1'b1;
            hit_frame <= cmp_idx;
            scan_done <= 1'b1;
            cmp_vld   <= 1'b0;
          end else if (!scan_done) begin
            if (scan_issue) begin
              cmp_vld  <= 1'b1;
              cmp_idx  <= scan_idx[FRAME_W-1:0];
              scan_idx <= CNT_W'(scan_idx + 1'b1);
            end else begin
              cmp_vld <= 1'b0;
              if (!cmp_vld) begin
                scan_done <= 1'b1;
              end
            end
          end

          if (decide) begin
            res_data <= '0;
            if (!rem_stat.aligned) begin
              res_status <= ST_UNALIGNED;
              state      <= S_RESP;
            end else if (req_write == REQ_READ) begin
              if (!hit) begin
                res_status <= ST_UNMAPPED;
                state      <= S_RESP;
              end else if (!size_is_pow2(req_size)) begin
                res_status <= ST_BAD_SIZE;
                state      <= S_RESP;
              end else begin
                state <= S_ACCESS;
              end
            end else if (!hit && frames_full) begin
              res_status <= ST_NO_FRAME;
              state      <= S_RESP;
            end else begin
              if (!hit) begin
                hit           <= 1'b1;
                hit_frame     <= frames_in_use[FRAME_W-1:0];
                frames_in_use <= CNT_W'(frames_in_use + 1'b1);
              end
              if (!write_size_ok) begin
                res_status <= ST_BAD_SIZE;
                state      <= S_RESP;
              end else begin
                state <= S_ACCESS;
              end
            end
          end
        end

        S_ACCESS: begin
          res_status <= ST_OK;
          res_data   <= (req_write == REQ_WRITE) ? '0 : rd_val;
          state      <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == S_RESP && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        read_data <= res_data;
        status    <= res_status;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_frames_bound: assert property (@(posedge clk) disable iff (rst)
    frames_in_use <= CNT_W'(FRAME_COUNT))
    else $error("frames_in_use beyond frame count");

  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    tag_we |-> (frames_in_use < CNT_W'(FRAME_COUNT)) && (req_write == REQ_WRITE))
    else $error("frame allocated with no free frame");

  a_store_write: assert property (@(posedge clk) disable iff (rst)
    (store_we && state != S_CLEAR) |-> (hit && $past(store_re)))
    else $error("store written without a matching read");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (read_data == '0))
    else $error("error response carries data");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !(out_valid && $rose(out_valid)))
    else $error("response raised during store clear");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_demand_paged_byte_memory.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_demand_paged_byte_memory
// Self-checking bench for the demand paged byte memory. Requests go in through
// a queue-fed driver. A shadow page table and a sparse copy of the frame store
// predict every response, and a monitor checks each response in order. The
// request side and the response side both idle and stall at random.
// ----------------------------------------------------------------------------
module tb_demand_paged_byte_memory;
  import dpbm_pkg::*;

  localparam int PAGE_BYTES      = 4096;
  localparam int FRAME_COUNT     = 16;
  localparam int WORDS_PER_FRAME = PAGE_BYTES / 8;
  localparam int POOL_PAGES      = 20;     // more pages than frames: forces exhaustion
  localparam int WATCHDOG_CYCLES = 40000;  // covers the clear sweep after reset
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES     = 64;
  localparam int MAX_REPORTS     = 25;

  typedef struct {
    logic               is_wr;
    logic [ADDR_W-1:0]  addr;
    logic [SIZE_W-1:0]  size;
    logic [WDATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct {
    logic [ADDR_W-1:0]   addr;   // kept only for mismatch messages
    logic [RDATA_W-1:0]  rdata;
    logic [STATUS_W-1:0] stat;
  } mem_resp_t;

  // DUT ports; the inputs are known from time zero
  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic                req_type   = REQ_READ;
  logic [ADDR_W-1:0]   address    = '0;
  logic [SIZE_W-1:0]   size_bytes = '0;
  logic [WDATA_W-1:0]  write_data = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [RDATA_W-1:0]  read_data;
  logic [STATUS_W-1:0] status;

  // Shadow copy of the block's state: page tag per bound frame, frame count,
  // and a sparse word store where a missing entry reads as zero.
  logic [19:0]        tag_of_frame [FRAME_COUNT];
  int                 frames_bound = 0;
  logic [63:0]        shadow_store [int unsigned];

  mem_req_t           req_queue [$];   // requests not yet offered
  mem_resp_t          resp_due  [$];   // predicted responses, oldest first
  mem_req_t           cur_req;
  logic [19:0]        page_pool [POOL_PAGES];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_token  = 0;   // bumped by the sequencer to ask for a long receiver stall
  int hold_seen   = 0;
  int hold_left   = 0;
  int idle_cycles = 0;
  int fail_count  = 0;
  int req_count   = 0;
  int resp_count  = 0;
  int status_hist [8];

  demand_paged_byte_memory #(
    .PAGE_BYTES (PAGE_BYTES),
    .FRAME_COUNT(FRAME_COUNT)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .address   (address),
    .size_bytes(size_bytes),
    .write_data(write_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .status    (status)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor: applies one request to the shadow state and returns the
  // response it must produce. Checks go in the block's priority order:
  // zero size, misalignment, unmapped read, frame binding on write, size.
  // --------------------------------------------------------------------------
  function automatic mem_resp_t paged_mem_access(mem_req_t r);
    mem_resp_t   resp;
    logic [19:0] page;
    logic [11:0] ofs;
    int          frame;
    int unsigned widx;
    int          lane;
    logic [63:0] mask;
    logic [63:0] word;
    page       = r.addr[31:12];
    ofs        = r.addr[11:0];
    resp.addr  = r.addr;
    resp.rdata = '0;
    resp.stat  = ST_OK;
    frame      = -1;
    if (r.size == 0) begin
      resp.stat = ST_BAD_SIZE;
    end else if ((ofs % r.size) != 0) begin
      // applies to odd sizes too, e.g. size 3 at offset 4
      resp.stat = ST_UNALIGNED;
    end else begin
      for (int i = 0; i < frames_bound; i++)
        if (frame < 0 && tag_of_frame[i] == page) frame = i;
      if (r.is_wr == REQ_READ) begin
        if (frame < 0) begin
          resp.stat = ST_UNMAPPED;
        end else if (r.size != 1 && r.size != 2 && r.size != 4 && r.size != 8) begin
          resp.stat = ST_BAD_SIZE;
        end else begin
          widx = frame * WORDS_PER_FRAME + ofs / 8;
          lane = ofs % 8;
          word = shadow_store.exists(widx) ? shadow_store[widx] : 64'd0;
          mask = (r.size == 8) ? '1 : (64'd1 << (8 * r.size)) - 64'd1;
          resp.rdata = (word >> (8 * lane)) & mask;
        end
      end else begin
        // a new page is bound before the size is judged
        if (frame < 0) begin
          if (frames_bound < FRAME_COUNT) begin
            frame = frames_bound;
            tag_of_frame[frames_bound] = page;
            frames_bound++;
          end else begin
            resp.stat = ST_NO_FRAME;
          end
        end
        if (resp.stat == ST_OK) begin
          if (r.size != 1 && r.size != 2 && r.size != 4) begin
            resp.stat = ST_BAD_SIZE;
          end else begin
            widx = frame * WORDS_PER_FRAME + ofs / 8;
            lane = ofs % 8;
            word = shadow_store.exists(widx) ? shadow_store[widx] : 64'd0;
            mask = ((64'd1 << (8 * r.size)) - 64'd1) << (8 * lane);
            shadow_store[widx] = (word & ~mask) | ((64'(r.wdata) << (8 * lane)) & mask);
          end
        end
      end
    end
    return resp;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  function automatic void push_req(logic wr, logic [31:0] addr, logic [3:0] sz,
                                   logic [31:0] data);
    mem_req_t r;
    r.is_wr = wr;
    r.addr  = addr;
    r.size  = sz;
    r.wdata = data;
    req_queue.push_back(r);
  endfunction

  // Well-formed access: legal size, aligned offset, page from the pool.
  // Offsets lean toward the first 64 bytes and pages toward the first few
  // of the pool so that reads often land on data written earlier.
  function automatic void push_clean_access();
    logic        wr;
    int          sz;
    int          idx;
    logic [11:0] ofs;
    wr  = 1'($urandom_range(1));
    sz  = 1 << $urandom_range(wr ? 2 : 3);
    idx = ($urandom_range(99) < 60) ? $urandom_range(5) : $urandom_range(POOL_PAGES - 1);
    ofs = $urandom_range(1) ? 12'($urandom_range(63)) : 12'($urandom);
    ofs = ofs & ~12'(sz - 1);
    push_req(wr, {page_pool[idx], ofs}, 4'(sz), $urandom);
  endfunction

  // Noise: any size, any offset, sometimes a page far outside the pool.
  function automatic void push_noise_access();
    logic [31:0] addr;
    addr = $urandom;
    if ($urandom_range(1)) addr[31:12] = page_pool[$urandom_range(POOL_PAGES - 1)];
    push_req(1'($urandom_range(1)), addr, 4'($urandom_range(15)), $urandom);
  endfunction

  function automatic void push_random(int n);
    for (int i = 0; i < n; i++)
      if ($urandom_range(99) < 85) push_clean_access();
      else push_noise_access();
  endfunction

  // Sender pause: nothing new goes out until every predicted response is back.
  task automatic wait_drained();
    while (req_queue.size() != 0 || in_valid || resp_due.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Request driver. A transaction completes on an edge with valid and ready
  // high; the accepted item is predicted right there. A new item is loaded
  // only when the channel is free, so valid and payload stay put while stalled.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        resp_due.push_back(paged_mem_access(cur_req));
        req_count++;
      end
      if (!in_valid || in_ready) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_req = req_queue.pop_front();
          in_valid   <= 1'b1;
          req_type   <= cur_req.is_wr;
          address    <= cur_req.addr;
          size_bytes <= cur_req.size;
          write_data <= cur_req.wdata;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor and receiver. Each accepted response is checked against
  // the oldest prediction. A change of hold_token starts a long stall that is
  // counted down here, so the block backs up and drops in_ready.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    mem_resp_t exp_resp;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        resp_count++;
        status_hist[status]++;
        if (resp_due.size() == 0) begin
          report_mismatch($sformatf("response with none pending: data=%h status=%0d",
                                    read_data, status));
        end else begin
          exp_resp = resp_due.pop_front();
          if (read_data !== exp_resp.rdata)
            report_mismatch($sformatf("addr %h read_data got %h want %h",
                                      exp_resp.addr, read_data, exp_resp.rdata));
          if (status !== exp_resp.stat)
            report_mismatch($sformatf("addr %h status got %0d want %0d",
                                      exp_resp.addr, status, exp_resp.stat));
        end
      end
      if (hold_seen != hold_token) begin
        hold_seen <= hold_token;
        hold_left <= RX_HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: ends the run after too long without any transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("[%0t] TIMEOUT: no transaction for %0d cycles", $time, idle_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer. Works on falling edges so queue pushes and knob changes never
  // race the clocked processes above.
  // --------------------------------------------------------------------------
  initial begin
    foreach (status_hist[i]) status_hist[i] = 0;
    page_pool[0] = 20'h00000;
    page_pool[1] = 20'hFFFFF;
    for (int i = 2; i < POOL_PAGES; i++) page_pool[i] = 20'($urandom);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: error ordering, lowest and highest page, byte lanes.
    tx_idle_pct = 16;
    rx_idle_pct = 47;
    push_req(REQ_READ,  32'h0000_0000, 4'd4,  32'h0);          // unmapped page
    push_req(REQ_READ,  32'h0000_0000, 4'd0,  32'h0);          // zero size read
    push_req(REQ_WRITE, 32'h0000_0000, 4'd0,  32'hFFFF_FFFF);  // zero size write, no bind
    push_req(REQ_WRITE, 32'h0000_1001, 4'd2,  32'h1);          // misaligned write
    push_req(REQ_READ,  32'h0000_1003, 4'd3,  32'h0);          // odd size, unmapped wins
    push_req(REQ_WRITE, 32'h0000_0000, 4'd3,  32'h1234_5678);  // binds page, then bad size
    push_req(REQ_READ,  32'h0000_0000, 4'd3,  32'h0);          // mapped, bad size
    push_req(REQ_READ,  32'h0000_0000, 4'd8,  32'h0);          // fresh frame reads zero
    push_req(REQ_WRITE, 32'h0000_0000, 4'd4,  32'hDEAD_BEEF);
    push_req(REQ_WRITE, 32'h0000_0004, 4'd2,  32'h1234_CAFE);  // upper bytes dropped
    push_req(REQ_WRITE, 32'h0000_0007, 4'd1,  32'hFFFF_FF80);
    push_req(REQ_READ,  32'h0000_0000, 4'd8,  32'h0);
    push_req(REQ_READ,  32'h0000_0006, 4'd2,  32'h0);
    push_req(REQ_WRITE, 32'h0000_0000, 4'd8,  32'h0);          // 8-byte write is illegal
    push_req(REQ_WRITE, 32'hFFFF_FFFC, 4'd4,  32'hFFFF_FFFF);  // top page
    push_req(REQ_READ,  32'hFFFF_FFF8, 4'd8,  32'h0);
    push_req(REQ_READ,  32'hFFFF_FFFF, 4'd1,  32'h0);
    push_req(REQ_READ,  32'hFFFF_FFFE, 4'd2,  32'h0);
    push_req(REQ_READ,  32'hFFFF_F00F, 4'd15, 32'h0);          // aligned for 15, bad size
    push_req(REQ_WRITE, 32'h0000_0FFE, 4'd2,  32'h0000_A5A5);  // last bytes of a page
    push_req(REQ_READ,  32'h0000_0FF8, 4'd8,  32'h0);
    push_req(REQ_READ,  32'h0000_0003, 4'd4,  32'h0);          // misaligned read
    push_req(REQ_WRITE, 32'h0000_0FFF, 4'd4,  32'h0);
    push_req(REQ_WRITE, 32'h0000_0008, 4'd4,  32'h0000_0000);
    wait_drained();

    // Back-pressure: receiver stalls for a long stretch while the sender
    // keeps offering, so the output register fills and in_ready drops.
    tx_idle_pct = 0;
    hold_token  = hold_token + 1;
    push_random(40);
    wait_drained();

    tx_idle_pct = 16;
    rx_idle_pct = 47;
    push_random(200);
    wait_drained();

    tx_idle_pct = 47;
    rx_idle_pct = 16;
    push_random(200);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    push_random(160);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d requests and %0d responses, %0d of %0d frames bound",
             req_count, resp_count, frames_bound, FRAME_COUNT);
    $display("Statuses seen: ok %0d, unaligned %0d, unmapped %0d, bad size %0d, no frame %0d",
             status_hist[ST_OK], status_hist[ST_UNALIGNED], status_hist[ST_UNMAPPED],
             status_hist[ST_BAD_SIZE], status_hist[ST_NO_FRAME]);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
